>>> design/pqcf_pkg.sv
// ----------------------------------------------------------------------------
// pqcf_pkg
// Shared widths, codes and reset values for the probe query coverage filter.
// ----------------------------------------------------------------------------
`default_nettype none

package pqcf_pkg;

   localparam int KIND_W     = 2;
   localparam int FLAGS_W    = 8;
   localparam int ADDR_W     = 32;
   localparam int IDX_W      = 3;
   localparam int TIME_W     = 48;
   localparam int WIN_W      = 32;
   localparam int NEED_W     = 3;
   localparam int SEEN_W     = 3;
   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 32;

   localparam logic [SEEN_W-1:0] SEEN_MAX = '1;

   // packet kinds
   localparam logic [KIND_W-1:0] KIND_TCP = 2'd0;
   localparam logic [KIND_W-1:0] KIND_DNS = 2'd1;

   // tcp flag combinations that pass
   localparam logic [FLAGS_W-1:0] FLAGS_SYNACK = 8'h12;
   localparam logic [FLAGS_W-1:0] FLAGS_FINACK = 8'h11;

   // configuration register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_WINDOW_MS    = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_NAMES_NEEDED = 2'd1;

   localparam logic [WIN_W-1:0]  WINDOW_RESET = 32'd10000;
   localparam logic [NEED_W-1:0] NEEDED_RESET = 3'd6;

   function automatic logic verdict_pass(input logic [KIND_W-1:0]  kind,
                                         input logic [FLAGS_W-1:0] flags);
      return (kind != KIND_TCP) || (flags == FLAGS_SYNACK) || (flags == FLAGS_FINACK);
   endfunction

endpackage

`default_nettype wire

>>> design/pqcf_ram.sv
// ----------------------------------------------------------------------------
// pqcf_ram
// Generic single write port, single read port RAM with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module pqcf_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 64
) (
   input  wire logic                                      clock,
   input  wire logic                                      wr_en,
   input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]                          wr_data,
   input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
   output      logic [WIDTH-1:0]                          rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

>>> design/probe_query_coverage_filter_core.sv
// Pipeline: a taken item passes the input, update and result registers to rsp_valid.
// Throughput: one item per cycle while busy is low; the host match runs across all
// address registers in parallel; entry RAM reads once, writes at most once per item.
// Reset: synchronous; clears the pipeline and all entry valid bits and reloads the
// configuration reset values at once, with no clearing pass. busy is high
// during reset and for the first cycle after it. The receiver cannot stall results.
// ----------------------------------------------------------------------------
// probe_query_coverage_filter_core
// Packet verdicts plus per-host tracking of watched DNS names.
// ----------------------------------------------------------------------------
`default_nettype none

module probe_query_coverage_filter_core #(
   parameter int HOST_ENTRIES = 64,
   parameter int NAME_COUNT   = 6
) (
   input  wire logic                               clock,
   input  wire logic                               reset,
   input  wire logic                               start,
   output      logic                               busy,
   input  wire logic [pqcf_pkg::KIND_W-1:0]        req_pkt_kind,
   input  wire logic [pqcf_pkg::FLAGS_W-1:0]       req_tcp_flags,
   input  wire logic [pqcf_pkg::ADDR_W-1:0]        req_src_addr,
   input  wire logic                               req_name_hit,
   input  wire logic [pqcf_pkg::IDX_W-1:0]         req_name_index,
   input  wire logic [pqcf_pkg::TIME_W-1:0]        req_now_ms,
   output      logic                               rsp_valid,
   output      logic                               rsp_accept,
   output      logic                               rsp_is_probe,
   output      logic [pqcf_pkg::SEEN_W-1:0]        rsp_names_seen,
   output      logic                               rsp_table_full,
   input  wire logic                               csr_valid,
   output      logic                               csr_ready,
   input  wire logic [pqcf_pkg::CSR_IDX_W-1:0]     csr_index,
   input  wire logic [pqcf_pkg::CSR_DATA_W-1:0]    csr_data
);

   import pqcf_pkg::*;

   localparam int SLOT_W  = (HOST_ENTRIES > 1) ? $clog2(HOST_ENTRIES) : 1;
   localparam int CNT_W   = $clog2(NAME_COUNT + 1);
   localparam int CMP_W   = (CNT_W > NEED_W) ? CNT_W : NEED_W;
   localparam int IDXC_W  = (CNT_W > IDX_W) ? CNT_W : IDX_W;
   localparam int ENTRY_W = NAME_COUNT + TIME_W + 1;

   function automatic logic [CNT_W-1:0] count_names(input logic [NAME_COUNT-1:0] v);
      logic [CNT_W-1:0] n;
      n = '0;
      for (int i = 0; i < NAME_COUNT; i++) begin
         n = n + CNT_W'(v[i]);
      end
      return n;
   endfunction

   // configuration and control
   logic              busy_ff;
   logic [WIN_W-1:0]  window_ff;
   logic [NEED_W-1:0] needed_ff;

   // input register
   logic                  in_valid_ff;
   logic [KIND_W-1:0]     in_kind_ff;
   logic [FLAGS_W-1:0]    in_flags_ff;
   logic [ADDR_W-1:0]     in_addr_ff;
   logic                  in_hit_ff;
   logic [IDX_W-1:0]      in_idx_ff;
   logic [TIME_W-1:0]     in_now_ff;

   // host address table
   logic [HOST_ENTRIES-1:0] ent_valid_ff;
   logic [ADDR_W-1:0]       ent_addr_ff [HOST_ENTRIES];

   // lookup stage
   logic                  lk_upd;
   logic                  lk_pass;
   logic                  lk_match_any;
   logic                  lk_free_any;
   logic [SLOT_W-1:0]     lk_match_slot;
   logic [SLOT_W-1:0]     lk_free_slot;
   logic [SLOT_W-1:0]     lk_slot;
   logic                  lk_alloc;
   logic                  lk_full;
   logic [NAME_COUNT-1:0] lk_bit;

   // update stage
   logic                  s2_valid_ff;
   logic                  s2_upd_ff;
   logic                  s2_new_ff;
   logic                  s2_full_ff;
   logic                  s2_pass_ff;
   logic [SLOT_W-1:0]     s2_slot_ff;
   logic [NAME_COUNT-1:0] s2_bit_ff;
   logic [TIME_W-1:0]     s2_now_ff;

   // last entry write, forwarded to the item right behind it
   logic                  fw_valid_ff;
   logic [SLOT_W-1:0]     fw_slot_ff;
   logic [ENTRY_W-1:0]    fw_data_ff;

   logic [ENTRY_W-1:0]    ram_rd_data;
   logic [ENTRY_W-1:0]    cur_entry;
   logic [NAME_COUNT-1:0] cur_names;
   logic [TIME_W-1:0]     cur_time;
   logic                  cur_probe;
   logic                  expired;
   logic [NAME_COUNT-1:0] merged;
   logic [CMP_W-1:0]      merged_cnt;
   logic [NAME_COUNT-1:0] nxt_names;
   logic [TIME_W-1:0]     nxt_time;
   logic                  nxt_probe;
   logic [ENTRY_W-1:0]    nxt_entry;
   logic [CMP_W-1:0]      seen_wide;
   logic [SEEN_W-1:0]     seen_sat;

   // result register
   logic              rsp_valid_ff;
   logic              rsp_accept_ff;
   logic              rsp_probe_ff;
   logic [SEEN_W-1:0] rsp_seen_ff;
   logic              rsp_full_ff;

   logic              take;

   assign take      = start && !busy_ff;
   assign busy      = busy_ff;
   assign csr_ready = !busy_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff   <= 1'b1;
         window_ff <= WINDOW_RESET;
         needed_ff <= NEEDED_RESET;
      end else begin
         busy_ff <= 1'b0;
         if (csr_valid && csr_ready) begin
            unique case (csr_index)
               CSR_WINDOW_MS:    window_ff <= csr_data[WIN_W-1:0];
               CSR_NAMES_NEEDED: needed_ff <= csr_data[NEED_W-1:0];
               default: ;
            endcase
         end
      end
   end

   // ------------------------------------------------------------------ input
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else begin
         in_valid_ff <= take;
      end
      if (take) begin
         in_kind_ff  <= req_pkt_kind;
         in_flags_ff <= req_tcp_flags;
         in_addr_ff  <= req_src_addr;
         in_hit_ff   <= req_name_hit;
         in_idx_ff   <= req_name_index;
         in_now_ff   <= req_now_ms;
      end
   end

   // ----------------------------------------------------------------- lookup
   always_comb begin
      lk_pass = verdict_pass(in_kind_ff, in_flags_ff);
      lk_upd  = in_valid_ff && (in_kind_ff == KIND_DNS) && in_hit_ff &&
                (IDXC_W'(in_idx_ff) < IDXC_W'(NAME_COUNT));
      for (int i = 0; i < NAME_COUNT; i++) begin
         lk_bit[i] = (IDXC_W'(in_idx_ff) == IDXC_W'(i));
      end
      lk_match_any  = 1'b0;
      lk_free_any   = 1'b0;
      lk_match_slot = '0;
      lk_free_slot  = '0;
      // scan downward so the lowest entry wins
      for (int i = HOST_ENTRIES - 1; i >= 0; i--) begin
         if (ent_valid_ff[i] && (ent_addr_ff[i] == in_addr_ff)) begin
            lk_match_any  = 1'b1;
            lk_match_slot = SLOT_W'(i);
         end
         if (!ent_valid_ff[i]) begin
            lk_free_any  = 1'b1;
            lk_free_slot = SLOT_W'(i);
         end
      end
      lk_slot  = lk_match_any ? lk_match_slot : lk_free_slot;
      lk_alloc = lk_upd && !lk_match_any && lk_free_any;
      lk_full  = lk_upd && !lk_match_any && !lk_free_any;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ent_valid_ff <= '0;
      end else if (lk_alloc) begin
         ent_valid_ff[lk_free_slot] <= 1'b1;
      end
      if (lk_alloc) begin
         ent_addr_ff[lk_free_slot] <= in_addr_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s2_valid_ff <= 1'b0;
      end else begin
         s2_valid_ff <= in_valid_ff;
      end
      s2_upd_ff  <= lk_upd && !lk_full;
      s2_new_ff  <= lk_alloc;
      s2_full_ff <= lk_full;
      s2_pass_ff <= lk_pass;
      s2_slot_ff <= lk_slot;
      s2_bit_ff  <= lk_bit;
      s2_now_ff  <= in_now_ff;
   end

   pqcf_ram #(
      .WIDTH (ENTRY_W),
      .DEPTH (HOST_ENTRIES)
   ) u_entry_ram (
      .clock   (clock),
      .wr_en   (s2_valid_ff && s2_upd_ff),
      .wr_addr (s2_slot_ff),
      .wr_data (nxt_entry),
      .rd_addr (lk_slot),
      .rd_data (ram_rd_data)
   );

   // ----------------------------------------------------------------- update
   always_comb begin
      cur_entry  = (fw_valid_ff && (fw_slot_ff == s2_slot_ff)) ? fw_data_ff : ram_rd_data;
      cur_names  = cur_entry[NAME_COUNT-1:0];
      cur_time   = cur_entry[NAME_COUNT +: TIME_W];
      cur_probe  = cur_entry[ENTRY_W-1];
      expired    = ({1'b0, cur_time} + (TIME_W + 1)'(window_ff)) < {1'b0, s2_now_ff};
      merged     = cur_names | s2_bit_ff;
      merged_cnt = CMP_W'(count_names(merged));
      priority if (s2_new_ff) begin
         nxt_names = s2_bit_ff;
         nxt_time  = s2_now_ff;
         nxt_probe = 1'b0;
      end else if (cur_probe) begin
         // probe mark is sticky: hold the entry
         nxt_names = cur_names;
         nxt_time  = cur_time;
         nxt_probe = 1'b1;
      end else if (expired) begin
         nxt_names = s2_bit_ff;
         nxt_time  = s2_now_ff;
         nxt_probe = 1'b0;
      end else if (merged_cnt >= CMP_W'(needed_ff)) begin
         nxt_names = merged;
         nxt_time  = cur_time;
         nxt_probe = 1'b1;
      end else begin
         nxt_names = merged;
         nxt_time  = s2_now_ff;
         nxt_probe = 1'b0;
      end
      nxt_entry = {nxt_probe, nxt_time, nxt_names};
      seen_wide = CMP_W'(count_names(nxt_names));
      seen_sat  = (seen_wide > CMP_W'(SEEN_MAX)) ? SEEN_MAX : seen_wide[SEEN_W-1:0];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         fw_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         fw_valid_ff  <= s2_valid_ff && s2_upd_ff;
         rsp_valid_ff <= s2_valid_ff;
      end
      fw_slot_ff    <= s2_slot_ff;
      fw_data_ff    <= nxt_entry;
      rsp_accept_ff <= s2_pass_ff;
      rsp_probe_ff  <= s2_upd_ff && nxt_probe;
      rsp_seen_ff   <= s2_upd_ff ? seen_sat : '0;
      rsp_full_ff   <= s2_full_ff;
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_accept     = rsp_accept_ff;
   assign rsp_is_probe   = rsp_probe_ff;
   assign rsp_names_seen = rsp_seen_ff;
   assign rsp_table_full = rsp_full_ff;

endmodule

`default_nettype wire

>>> design/pqcf_checker.sv
// ----------------------------------------------------------------------------
// pqcf_checker
// Port-level checks for the probe query coverage filter, bound to the core.
// ----------------------------------------------------------------------------
`default_nettype none

module pqcf_checker (
   input wire logic                          clock,
   input wire logic                          reset,
   input wire logic                          start,
   input wire logic                          busy,
   input wire logic [pqcf_pkg::KIND_W-1:0]   req_pkt_kind,
   input wire logic [pqcf_pkg::FLAGS_W-1:0]  req_tcp_flags,
   input wire logic                          rsp_valid,
   input wire logic                          rsp_accept,
   input wire logic                          rsp_is_probe,
   input wire logic [pqcf_pkg::SEEN_W-1:0]   rsp_names_seen,
   input wire logic                          rsp_table_full
);

   import pqcf_pkg::*;

   // every taken item yields a result
   a_item_gives_result: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |-> ##3 rsp_valid)
      else $error("taken item produced no result");

   // no result without an earlier taken item
   a_no_invented_result: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> $past(start && !busy, 3))
      else $error("result without a taken item");

   // a drop only comes from a tcp packet with a rejected flag byte
   a_drop_is_tcp: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_accept) |->
         $past((req_pkt_kind == KIND_TCP) && (req_tcp_flags != FLAGS_SYNACK) &&
               (req_tcp_flags != FLAGS_FINACK), 3))
      else $error("drop verdict for a packet that should pass");

   // dropped packets never touch host tracking
   a_drop_no_tracking: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_accept) |->
         (!rsp_is_probe && (rsp_names_seen == '0) && !rsp_table_full))
      else $error("dropped packet reports host tracking");

   // an untracked host reports nothing else and still passes
   a_full_untracked: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_table_full) |->
         (rsp_accept && !rsp_is_probe && (rsp_names_seen == '0)))
      else $error("table full result carries tracking data");

endmodule

bind probe_query_coverage_filter_core pqcf_checker u_pqcf_checker (.*);

`default_nettype wire
